### design/sorted_event_queue_unit_assert.svh
// Assertion macros shared by the sorted event queue modules.
`ifndef SORTED_EVENT_QUEUE_UNIT_ASSERT_SVH
`define SORTED_EVENT_QUEUE_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/seq_pkg.sv
// Types and constants of the sorted event queue.
`timescale 1ns / 1ps
`default_nettype none
package seq_pkg;
    localparam int ID_W   = 32;
    localparam int TIME_W = 20;
    localparam int CNT_W  = 5;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_RETIME = 3'd3;
    localparam logic [2:0] OP_PEEK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [ID_W-1:0]   item_id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] service;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [TIME_W-1:0] out_arrival;
        logic [TIME_W-1:0] out_service;
        logic [TIME_W-1:0] head_arrival;
        logic [TIME_W:0]   head_departure;
        logic [CNT_W-1:0]  entry_count;
        logic              not_empty;
    } t_out_item;

    // Classified command handed from front to back.
    typedef enum logic [2:0] {
        CMD_APPEND, CMD_INSERT, CMD_POP, CMD_RETIME, CMD_PEEK
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [ID_W-1:0]   item_id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] service;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_REPORT, S_OUT
    } t_state;
endpackage
`default_nettype wire

### design/seq_front.sv
// Front end: accepts beats, decodes opcodes, queues jobs for the back end.
`timescale 1ns / 1ps
`default_nettype none
module seq_front import seq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_job_valid,
    input  wire logic     i_job_take,
    output t_job          o_job
);
    // two-entry job queue
    t_job       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    t_job       w_job;
    logic       w_push, w_pop;

    always_comb begin
        w_job.item_id = i_item.item_id;
        w_job.arrival = i_item.arrival;
        w_job.service = i_item.service;
        unique case (i_item.opcode)
            OP_APPEND: w_job.cmd = CMD_APPEND;
            OP_INSERT: w_job.cmd = CMD_INSERT;
            OP_POP:    w_job.cmd = CMD_POP;
            OP_RETIME: w_job.cmd = CMD_RETIME;
            default:   w_job.cmd = CMD_PEEK;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_job_take && (r_cnt != 2'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];
    assign n_cnt       = r_cnt + {1'b0, w_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
        end
        if (w_push) r_q[r_wr] <= w_job;
    end

`include "sorted_event_queue_unit_assert.svh"
    `SEQ_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `SEQ_ASSERT_NXT(a_full_stall, i_clk, i_rst_n, r_cnt == 2'd2 && !w_pop, o_stall)
    `SEQ_ASSERT_IMP(a_ptr_match, i_clk, i_rst_n, r_cnt != 2'd1, r_rd == r_wr)
endmodule
`default_nettype wire

### design/seq_back.sv
// Back end: entry store, ordered scan and shift, result register.
`timescale 1ns / 1ps
`default_nettype none
module seq_back import seq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    output logic      o_job_take,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out_item o_item
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [ID_W-1:0]   r_id  [CAPACITY];
    logic [TIME_W-1:0] r_ta  [CAPACITY];
    logic [TIME_W-1:0] r_ts  [CAPACITY];
    logic [CW-1:0]     r_count;
    t_state            r_state, n_state;
    t_job              r_job;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_k, n_k;
    logic [1:0]        r_status, n_status;
    logic [ID_W-1:0]   r_pid;
    logic [TIME_W-1:0] r_pta, r_pts;
    logic              r_popped;
    t_out_item         r_out;
    logic              r_ovalid;

    logic              w_full, w_empty;
    logic [TIME_W:0]   w_sum;
    logic [TIME_W-1:0] w_sat;
    logic [TIME_W:0]   w_dep;

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_sum   = {1'b0, r_job.arrival} + {1'b0, r_job.service};
    assign w_sat   = w_sum[TIME_W] ? '1 : w_sum[TIME_W-1:0];
    assign w_dep   = {1'b0, r_ta[0]} + {1'b0, r_ts[0]};
    assign o_job_take = (r_state == S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_item     = r_out;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_k      = r_k;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                n_pos = CW'(1);
                if (i_job_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                // classify against fill and walk to insert point
                n_status = ST_OK;
                unique case (r_job.cmd)
                    CMD_APPEND, CMD_INSERT: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                            n_state  = S_REPORT;
                        end else if (r_job.cmd == CMD_APPEND) begin
                            n_pos   = r_count;
                            n_k     = r_count;
                            n_state = S_SHIFT;
                        end else if (w_empty || r_job.arrival < r_ta[0]) begin
                            n_pos   = '0;
                            n_k     = r_count;
                            n_state = S_SHIFT;
                        end else if (r_pos < r_count &&
                                     r_ta[r_pos[IW-1:0]] < r_job.arrival) begin
                            n_pos = r_pos + 1'b1;
                        end else begin
                            n_k     = r_count;
                            n_state = S_SHIFT;
                        end
                    end
                    default: begin
                        if (w_empty) n_status = ST_EMPTY;
                        n_state = S_SHIFT;
                        n_k     = '0;
                    end
                endcase
            end
            S_SHIFT: begin
                if (r_job.cmd == CMD_APPEND || r_job.cmd == CMD_INSERT) begin
                    if (r_k == r_pos) n_state = S_REPORT;
                    else n_k = r_k - 1'b1;
                end else if (r_job.cmd == CMD_POP && r_status == ST_OK &&
                             r_k + 1'b1 < r_count) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: n_state = S_OUT;
            S_OUT:    if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            if (r_state == S_SHIFT && n_state == S_REPORT && r_status == ST_OK) begin
                if (r_job.cmd == CMD_APPEND || r_job.cmd == CMD_INSERT)
                    r_count <= r_count + 1'b1;
                else if (r_job.cmd == CMD_POP)
                    r_count <= r_count - 1'b1;
            end
        end
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_status <= n_status;
        if (r_state == S_IDLE) begin
            r_job    <= i_job;
            r_popped <= 1'b0;
        end
        if (r_state == S_SHIFT) begin
            unique case (r_job.cmd)
                CMD_APPEND, CMD_INSERT: begin
                    // one entry moves up per cycle, then the new one lands
                    if (r_k == r_pos) begin
                        r_id[r_k[IW-1:0]] <= r_job.item_id;
                        r_ta[r_k[IW-1:0]] <= r_job.arrival;
                        r_ts[r_k[IW-1:0]] <= r_job.service;
                    end else begin
                        r_id[r_k[IW-1:0]] <= r_id[IW'(r_k - 1'b1)];
                        r_ta[r_k[IW-1:0]] <= r_ta[IW'(r_k - 1'b1)];
                        r_ts[r_k[IW-1:0]] <= r_ts[IW'(r_k - 1'b1)];
                    end
                end
                CMD_POP: begin
                    if (r_status == ST_OK) begin
                        if (r_k == '0) begin
                            r_popped <= 1'b1;
                            r_pid    <= r_id[0];
                            r_pta    <= r_ta[0];
                            r_pts    <= r_ts[0];
                        end
                        if (r_k + 1'b1 < r_count) begin
                            r_id[r_k[IW-1:0]] <= r_id[IW'(r_k + 1'b1)];
                            r_ta[r_k[IW-1:0]] <= r_ta[IW'(r_k + 1'b1)];
                            r_ts[r_k[IW-1:0]] <= r_ts[IW'(r_k + 1'b1)];
                        end
                    end
                end
                CMD_RETIME: if (r_status == ST_OK) r_ta[0] <= w_sat;
                default: ;
            endcase
        end
        if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
            r_out.status      <= r_status;
            r_out.entry_count <= CNT_W'(r_count);
            r_out.not_empty   <= !w_empty;
            if (w_empty) begin
                r_out.head_arrival   <= '0;
                r_out.head_departure <= '0;
            end else begin
                r_out.head_arrival   <= r_ta[0];
                r_out.head_departure <= w_dep;
            end
            if (r_popped) begin
                r_out.out_id      <= r_pid;
                r_out.out_arrival <= r_pta;
                r_out.out_service <= r_pts;
            end else if (w_empty) begin
                r_out.out_id      <= '0;
                r_out.out_arrival <= '0;
                r_out.out_service <= '0;
            end else begin
                r_out.out_id      <= r_id[0];
                r_out.out_arrival <= r_ta[0];
                r_out.out_service <= r_ts[0];
            end
        end
    end

`include "sorted_event_queue_unit_assert.svh"
    `SEQ_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `SEQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ovalid && i_stall, r_ovalid && $stable(r_out))
    `SEQ_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_job_take, r_state == S_IDLE)
endmodule
`default_nettype wire

### design/sorted_event_queue_unit.sv
// Sorted event queue: each input beat yields one result beat.
// The back end takes the next beat only once it has finished the last one, and an output stall holds it.
// Sorted insert walks the store one entry per cycle, then shifts one entry per cycle.
// Pop shifts count-1 entries, one per cycle; append shifts none.
// A two-deep job queue in the front end accepts beats while the back end works.
// Synchronous active-low reset empties the queue; entry storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_event_queue_unit import seq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_item
);
    logic w_job_valid, w_job_take;
    t_job w_job;

    // front: decode and buffer
    seq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_job_valid(w_job_valid), .i_job_take(w_job_take), .o_job(w_job)
    );

    // back: store, scan, shift, report
    seq_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_job_valid), .o_job_take(w_job_take), .i_job(w_job),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );
endmodule
`default_nettype wire

### tb/tb_sorted_event_queue_unit.sv
// Testbench for the sorted event queue: directed and random beats checked against a model.
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_event_queue_unit;
    import seq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int WDOG_LIMIT = 4000;
    localparam int IN_W       = $bits(t_in_item);
    localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    sorted_event_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    // Shadow copy of the queue; index 0 is the head.
    logic [ID_W-1:0]   q_ids [DEPTH];
    logic [TIME_W-1:0] q_arr [DEPTH];
    logic [TIME_W-1:0] q_svc [DEPTH];
    int                q_cnt;

    t_out_item expected_results[$];
    int        fail_cnt;
    int        idle_cycles;
    int        sink_wait;    // stall cycles left after the last result beat
    bit        sink_quiet;   // forces the sink never to stall

    // Advance the shadow queue by one beat and build the result it should produce.
    function automatic t_out_item queue_apply(t_in_item it);
        t_out_item r;
        logic [TIME_W:0] sum;
        int pos;
        bit popped;
        r = '0;
        popped = 1'b0;
        r.status = ST_OK;
        case (it.opcode)
            OP_APPEND, OP_INSERT: begin
                if (q_cnt >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (it.opcode == OP_APPEND) pos = q_cnt;
                    else if (q_cnt == 0 || it.arrival < q_arr[0]) pos = 0;
                    else begin
                        // equal arrivals never displace the head
                        pos = 1;
                        while (pos < q_cnt && q_arr[pos] < it.arrival) pos++;
                    end
                    for (int k = q_cnt; k > pos; k--) begin
                        q_ids[k] = q_ids[k-1];
                        q_arr[k] = q_arr[k-1];
                        q_svc[k] = q_svc[k-1];
                    end
                    q_ids[pos] = it.item_id;
                    q_arr[pos] = it.arrival;
                    q_svc[pos] = it.service;
                    q_cnt++;
                end
            end
            OP_POP: begin
                if (q_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    popped = 1'b1;
                    r.out_id = q_ids[0];
                    r.out_arrival = q_arr[0];
                    r.out_service = q_svc[0];
                    for (int k = 0; k + 1 < q_cnt; k++) begin
                        q_ids[k] = q_ids[k+1];
                        q_arr[k] = q_arr[k+1];
                        q_svc[k] = q_svc[k+1];
                    end
                    q_cnt--;
                end
            end
            OP_RETIME: begin
                if (q_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    sum = {1'b0, it.arrival} + {1'b0, it.service};
                    q_arr[0] = sum[TIME_W] ? TMAX : sum[TIME_W-1:0];
                end
            end
            default: begin
                // peek, and undefined codes act as peek
                if (q_cnt == 0) r.status = ST_EMPTY;
            end
        endcase
        if (q_cnt > 0) begin
            r.head_arrival = q_arr[0];
            r.head_departure = {1'b0, q_arr[0]} + {1'b0, q_svc[0]};
            r.not_empty = 1'b1;
            if (!popped) begin
                r.out_id = q_ids[0];
                r.out_arrival = q_arr[0];
                r.out_service = q_svc[0];
            end
        end
        r.entry_count = CNT_W'(q_cnt);
        return r;
    endfunction

    // Send one beat after a random gap, none when no_gap is set; valid stays high across back-to-back beats.
    task automatic send_beat(input logic [2:0] op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] ta, input logic [TIME_W-1:0] ts,
                             input bit no_gap = 1'b0);
        t_in_item it;
        int gap;
        it.opcode = op;
        it.item_id = id;
        it.arrival = ta;
        it.service = ts;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.push_back(queue_apply(it));
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        i_item <= t_in_item'(IN_W'({$urandom, $urandom, $urandom}));
        @(posedge i_clk);
    endtask

    task automatic random_time(output logic [TIME_W-1:0] t);
        case ($urandom_range(0, 3))
            0: t = TIME_W'($urandom_range(0, 15));
            1: t = TMAX - TIME_W'($urandom_range(0, 15));
            default: t = TIME_W'($urandom);
        endcase
    endtask

    task automatic drain_all(input logic [2:0] op);
        while (q_cnt > 0) send_beat(op, '0, '0, '0);
    endtask

    // Empty queue, full queue, insert order with ties, retime saturation, odd codes.
    task automatic test_directed();
        send_beat(OP_POP, '0, '0, '0);
        send_beat(OP_RETIME, '1, TMAX, TMAX);
        send_beat(OP_PEEK, '0, '0, '0);
        send_beat(3'd7, '1, '1, '1);
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 20'd100, TMAX);
        send_beat(OP_INSERT, 32'h1, 20'd100, 20'd5, 1'b1);   // tie with head
        send_beat(OP_INSERT, 32'h2, 20'd50, 20'd0, 1'b1);    // new head
        send_beat(OP_INSERT, 32'h3, TMAX, 20'd1, 1'b1);
        send_beat(OP_INSERT, 32'h4, 20'd0, 20'd0, 1'b1);
        send_beat(OP_RETIME, '0, TMAX, 20'd1);               // saturates
        send_beat(OP_RETIME, '0, 20'd7, 20'd8);
        send_beat(3'd5, '0, '0, '0);
        send_beat(3'd6, '0, '0, '0);
        for (int k = 0; k < 12; k++)
            send_beat(OP_APPEND, ID_W'(k), TIME_W'(k), TIME_W'(k), 1'b1);
        send_beat(OP_APPEND, '1, '1, '1, 1'b1);              // full
        send_beat(OP_INSERT, '1, '0, '1, 1'b1);              // full
        drain_all(OP_POP);
    endtask

    // Mostly well-formed runs of inserts, appends, pops, retimes and peeks, with noise on every field.
    task automatic test_random(input int n);
        logic [TIME_W-1:0] ta, ts;
        logic [2:0] op;
        int sel;
        for (int i = 0; i < n; i++) begin
            random_time(ta);
            random_time(ts);
            sel = $urandom_range(0, 99);
            if (sel < 35) op = OP_INSERT;
            else if (sel < 50) op = OP_APPEND;
            else if (sel < 75) op = OP_POP;
            else if (sel < 85) op = OP_RETIME;
            else if (sel < 95) op = OP_PEEK;
            else op = 3'($urandom_range(5, 7));
            // bias toward filling the queue now and then
            if (q_cnt < 3 && sel < 60) op = OP_INSERT;
            if (ta[3:0] == 4'hF && q_cnt > 12) op = OP_APPEND;
            send_beat(op, ID_W'($urandom), ta, ts);
            if ($urandom_range(0, 63) == 0) go_idle();
        end
        i_valid <= 1'b0;
    endtask

    // Sink stall: after each result beat, stall the output for a randomly drawn wait, which may be none.
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n || sink_quiet) begin
            i_stall <= 1'b0;
            sink_wait <= 0;
        end else if (o_valid && !i_stall) begin
            w = $urandom_range(0, 8);
            sink_wait <= w;
            i_stall <= (w != 0);
        end else if (sink_wait > 1) begin
            sink_wait <= sink_wait - 1;
        end else begin
            sink_wait <= 0;
            i_stall <= 1'b0;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_item);
                fail_cnt++;
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.status !== o_item.status)
                    $display("%0t: status exp %h got %h", $time, exp_r.status,
                             o_item.status);
                if (exp_r.out_id !== o_item.out_id)
                    $display("%0t: out_id exp %h got %h", $time, exp_r.out_id,
                             o_item.out_id);
                if (exp_r.out_arrival !== o_item.out_arrival)
                    $display("%0t: out_arrival exp %h got %h", $time,
                             exp_r.out_arrival, o_item.out_arrival);
                if (exp_r.out_service !== o_item.out_service)
                    $display("%0t: out_service exp %h got %h", $time,
                             exp_r.out_service, o_item.out_service);
                if (exp_r.head_arrival !== o_item.head_arrival)
                    $display("%0t: head_arrival exp %h got %h", $time,
                             exp_r.head_arrival, o_item.head_arrival);
                if (exp_r.head_departure !== o_item.head_departure)
                    $display("%0t: head_departure exp %h got %h", $time,
                             exp_r.head_departure, o_item.head_departure);
                if (exp_r.entry_count !== o_item.entry_count)
                    $display("%0t: entry_count exp %h got %h", $time,
                             exp_r.entry_count, o_item.entry_count);
                if (exp_r.not_empty !== o_item.not_empty)
                    $display("%0t: not_empty exp %h got %h", $time,
                             exp_r.not_empty, o_item.not_empty);
                if (exp_r !== o_item) fail_cnt++;
            end
        end
    end

    // Watchdog on cycles with no beat moving either way.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        fail_cnt = 0;
        idle_cycles = 0;
        q_cnt = 0;
        sink_quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(800);
        sink_quiet <= 1'b1;
        test_random(100);
        sink_quiet <= 1'b0;
        test_random(800);
        drain_all(OP_POP);
        i_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (2 * DEPTH + 10) @(posedge i_clk);
        if (fail_cnt == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
